### hw/rtl/pfb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfb_pkg
// Shared types and constants for the padded frame builder with Adler-32.
// ---------------------------------------------------------------------------
package pfb_pkg;

    // Adler-32 modulus, one bit wider than the sums it reduces
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    // Padding target: length + overhead is a multiple of the block size,
    // so pad = (PAD_BASE - length) mod 16
    localparam logic [3:0] PAD_BASE = 4'd10;

    // Frame byte being produced for the item at the head
    typedef enum logic [7:0] {
        PH_HDR_HI  = 8'b0000_0001,
        PH_HDR_LO  = 8'b0000_0010,
        PH_PAYLOAD = 8'b0000_0100,
        PH_PAD     = 8'b0000_1000,
        PH_CK0     = 8'b0001_0000,
        PH_CK1     = 8'b0010_0000,
        PH_CK2     = 8'b0100_0000,
        PH_CK3     = 8'b1000_0000
    } pfb_phase_t;

    // Checksum update request from the sequencer
    typedef struct packed {
        logic       add;
        logic       restart;
        logic [7:0] data;
    } pfb_sum_req_t;

    // Running Adler sums
    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
    } pfb_sums_t;

    // One frame byte leaving the sequencer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       run_last;
        logic       frame_end;
    } pfb_beat_t;

endpackage

### hw/rtl/pfb_adler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfb_adler
// Running Adler-32 sums, updated by one byte per request.
// ---------------------------------------------------------------------------
module pfb_adler
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfb_pkg::pfb_sum_req_t req,
    output pfb_pkg::pfb_sums_t    sums
);

    logic [15:0] low_reg;
    logic [15:0] high_reg;
    logic [15:0] low_base;
    logic [15:0] high_base;
    logic [16:0] low_sum;
    logic [15:0] low_next;
    logic [16:0] high_sum;
    logic [15:0] high_next;

    // Start from the initial sums on the first byte of a frame
    assign low_base  = req.restart ? 16'd1 : low_reg;
    assign high_base = req.restart ? 16'd0 : high_reg;

    // Reduce each sum with a single compare and subtract
    always_comb
    begin
        low_sum = {1'b0, low_base} + {9'd0, req.data};
        if (low_sum >= pfb_pkg::ADLER_MOD)
        begin
            low_sum = low_sum - pfb_pkg::ADLER_MOD;
        end
        low_next = low_sum[15:0];

        high_sum = {1'b0, high_base} + {1'b0, low_next};
        if (high_sum >= pfb_pkg::ADLER_MOD)
        begin
            high_sum = high_sum - pfb_pkg::ADLER_MOD;
        end
        high_next = high_sum[15:0];
    end

    // Hold the sums between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= 16'd1;
            high_reg <= 16'd0;
        end
        else if (req.add)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign sums.low  = low_reg;
    assign sums.high = high_reg;

endmodule

### hw/rtl/pfb_emit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfb_emit
// Item register and frame sequencer: walks header, payload, padding and
// checksum bytes, one frame byte per step.
// ---------------------------------------------------------------------------
module pfb_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic [15:0]           in_length,
    input  logic                  in_ts,
    input  logic                  out_free,
    input  pfb_pkg::pfb_sums_t    sums,
    output pfb_pkg::pfb_sum_req_t sum_req,
    output pfb_pkg::pfb_beat_t    beat
);

    logic                item_valid_reg;
    logic [7:0]          item_byte_reg;
    logic [15:0]         item_len_reg;
    logic                item_ts_reg;
    pfb_pkg::pfb_phase_t phase_reg;
    pfb_pkg::pfb_phase_t phase_next;
    logic                in_frame_reg;
    logic                in_frame_next;
    logic [15:0]         bytes_left_reg;
    logic [15:0]         bytes_left_next;
    logic [3:0]          pad_left_reg;
    logic [3:0]          pad_left_next;

    logic                step;
    logic                load;
    logic                item_last;
    logic                frame_end;
    logic                add;
    logic                restart;
    logic [7:0]          emit_byte;
    logic [15:0]         eff_len;
    logic [15:0]         hdr;

    // Zero length counts as one byte, header included
    assign eff_len = (item_len_reg == 16'd0) ? 16'd1 : item_len_reg;
    assign hdr     = item_ts_reg ? 16'd0 : eff_len;

    // Advance one frame byte whenever the output register has room
    assign step     = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || (step && item_last);
    assign load     = in_valid && in_ready;

    // Select the frame byte and the state that follows it
    always_comb
    begin
        emit_byte       = 8'd0;
        item_last       = 1'b0;
        frame_end       = 1'b0;
        add             = 1'b0;
        restart         = 1'b0;
        phase_next      = phase_reg;
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        pad_left_next   = pad_left_reg;
        unique case (phase_reg)
            pfb_pkg::PH_HDR_HI:
            begin
                emit_byte       = hdr[15:8];
                add             = 1'b1;
                restart         = 1'b1;
                in_frame_next   = 1'b1;
                bytes_left_next = eff_len;
                pad_left_next   = pfb_pkg::PAD_BASE - eff_len[3:0];
                phase_next      = pfb_pkg::PH_HDR_LO;
            end
            pfb_pkg::PH_HDR_LO:
            begin
                emit_byte  = hdr[7:0];
                add        = 1'b1;
                phase_next = pfb_pkg::PH_PAYLOAD;
            end
            pfb_pkg::PH_PAYLOAD:
            begin
                emit_byte       = item_byte_reg;
                add             = 1'b1;
                bytes_left_next = bytes_left_reg - 16'd1;
                if (bytes_left_reg == 16'd1)
                begin
                    phase_next = (pad_left_reg != 4'd0) ? pfb_pkg::PH_PAD
                                                        : pfb_pkg::PH_CK0;
                end
                else
                begin
                    item_last = 1'b1;
                end
            end
            pfb_pkg::PH_PAD:
            begin
                add           = 1'b1;
                pad_left_next = pad_left_reg - 4'd1;
                if (pad_left_reg == 4'd1)
                begin
                    phase_next = pfb_pkg::PH_CK0;
                end
            end
            pfb_pkg::PH_CK0:
            begin
                emit_byte  = sums.high[15:8];
                phase_next = pfb_pkg::PH_CK1;
            end
            pfb_pkg::PH_CK1:
            begin
                emit_byte  = sums.high[7:0];
                phase_next = pfb_pkg::PH_CK2;
            end
            pfb_pkg::PH_CK2:
            begin
                emit_byte  = sums.low[15:8];
                phase_next = pfb_pkg::PH_CK3;
            end
            pfb_pkg::PH_CK3:
            begin
                emit_byte     = sums.low[7:0];
                item_last     = 1'b1;
                frame_end     = 1'b1;
                in_frame_next = 1'b0;
            end
            default:
            begin
                phase_next = pfb_pkg::PH_PAYLOAD;
            end
        endcase
    end

    // Hold the item and frame state; a new item starts at the header
    // or at its payload byte depending on whether a frame is open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= pfb_pkg::PH_HDR_HI;
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 16'd0;
            pad_left_reg   <= 4'd0;
        end
        else
        begin
            if (step)
            begin
                in_frame_reg   <= in_frame_next;
                bytes_left_reg <= bytes_left_next;
                pad_left_reg   <= pad_left_next;
            end
            if (load)
            begin
                item_valid_reg <= 1'b1;
                if (step ? in_frame_next : in_frame_reg)
                begin
                    phase_reg <= pfb_pkg::PH_PAYLOAD;
                end
                else
                begin
                    phase_reg <= pfb_pkg::PH_HDR_HI;
                end
            end
            else if (step)
            begin
                phase_reg <= phase_next;
                if (item_last)
                begin
                    item_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_byte_reg <= in_byte;
            item_len_reg  <= in_length;
            item_ts_reg   <= in_ts;
        end
    end

    assign sum_req.add     = step && add;
    assign sum_req.restart = restart;
    assign sum_req.data    = emit_byte;

    assign beat.valid     = step;
    assign beat.data      = emit_byte;
    assign beat.run_last  = item_last;
    assign beat.frame_end = frame_end;

endmodule

### hw/rtl/padded_frame_builder_adler32.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// padded_frame_builder_adler32
// Builds length-prefixed, zero-padded frames closed by an Adler-32 trailer.
// ---------------------------------------------------------------------------
// Usage:
//   Send payload bytes on the s_axis channel; the first byte of a message
//   also carries the length and the timestamp flag. The m_axis channel
//   carries the frame one byte per beat: two header bytes, the payload,
//   zero padding up to length + 6 a multiple of 16, then the Adler-32 as
//   s2 high, s2 low, s1 high, s1 low. tlast marks the last byte caused by
//   one request, tuser the final checksum byte of a frame.
//   The first byte of a request passes the item register, then the output
//   register. Throughput: one output byte per cycle while m_axis_tready is
//   high, set by the single sequencer stepping the output register; a first
//   byte adds the two header bytes, a last byte the padding and checksum.
//   A new request is taken in the cycle the previous one emits its last byte.
//   Reset clears the frame state and empties both registers; the next byte
//   starts a new message. When m_axis_tready is low the output register
//   holds its beat and the sequencer, and then s_axis_tready, stall.
// ---------------------------------------------------------------------------
module padded_frame_builder_adler32
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] payload_byte, [23:8] message_length
    input  logic        s_axis_tuser,   // [0] timestamp_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // [0] frame_end
);

    pfb_pkg::pfb_sum_req_t sum_req;
    pfb_pkg::pfb_sums_t    sums;
    pfb_pkg::pfb_beat_t    beat;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_end_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || m_axis_tready;

    pfb_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata[7:0]),
        .in_length (s_axis_tdata[23:8]),
        .in_ts     (s_axis_tuser),
        .out_free  (out_free),
        .sums      (sums),
        .sum_req   (sum_req),
        .beat      (beat)
    );

    pfb_adler u_adler
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sum_req),
        .sums  (sums)
    );

    // Output register: advance on a new beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (beat.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.valid)
        begin
            out_byte_reg <= beat.data;
            out_last_reg <= beat.run_last;
            out_end_reg  <= beat.frame_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_end_reg;

endmodule
